/* rtl/dele_pkg.sv */
// ----------------------------------------------------------------------------
// dele_pkg
// types and constants for the dual moving-average level and event detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dele_pkg;

  // q1.15 constants
  localparam logic [15:0] Q_ONE        = 16'd32768;
  localparam logic [31:0] Q_HALF       = 32'd16384;
  localparam logic [15:0] WEIGHT_RESET = 16'd3277;

  // event test
  localparam logic [15:0] FIRE_SAMPLE_MIN = 16'd22938;
  localparam logic [15:0] FIRE_AVG_ABOVE  = 16'd16384;

  // band thresholds
  localparam logic [15:0] BAND_FULL    = 16'd29492;
  localparam logic [15:0] BAND_HIGH    = 16'd22938;
  localparam logic [15:0] BAND_MEDIUM  = 16'd16384;
  localparam logic [15:0] BAND_LOW     = 16'd9831;
  localparam logic [15:0] BAND_NASCENT = 16'd3277;

  // band codes
  localparam logic [2:0] LB_DORMANT = 3'd0;
  localparam logic [2:0] LB_NASCENT = 3'd1;
  localparam logic [2:0] LB_LOW     = 3'd2;
  localparam logic [2:0] LB_MEDIUM  = 3'd3;
  localparam logic [2:0] LB_HIGH    = 3'd4;
  localparam logic [2:0] LB_FULL    = 3'd5;

  // saturation point of the event count
  localparam logic [5:0] EVENT_LIMIT = 6'd50;

  typedef struct packed {
    logic [15:0] ae_sample;
    logic [15:0] we_sample;
    logic [7:0]  dimension;
    logic [47:0] time_stamp;
  } item_in_t;

  typedef struct packed {
    logic [15:0] avg_ae;
    logic [15:0] avg_we;
    logic [15:0] level;
    logic [2:0]  level_band;
    logic        event_fired;
    logic [7:0]  event_dimension;
    logic [47:0] event_time;
    logic [5:0]  event_total;
  } item_out_t;

endpackage

/* rtl/dual_ema_level_event_detector_unit.sv */
// ----------------------------------------------------------------------------
// dual_ema_level_event_detector_unit
// sequence: an accepted item passes through the shared 16x16 multiplier (five
//   useful products), the bit-serial square root (16 steps) and the result
//   load in S_DONE; the next item is taken only once the unit is idle again
// reset: synchronous rst clears averages and event count and loads the weight (3277)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_ema_level_event_detector_unit (
  input  logic                clk,
  input  logic                rst,
  // input item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  dele_pkg::item_in_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output dele_pkg::item_out_t out_data,
  // weight register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import dele_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMA,
    S_SQRT,
    S_DONE
  } state_t;

  state_t      state;
  logic [2:0]  step;       // multiplier sequence position
  logic [3:0]  sq_idx;     // square root digit index, bit weight is 4**sq_idx

  // architectural state
  logic [15:0] weight;
  logic [15:0] ae_avg;
  logic [15:0] we_avg;
  logic [5:0]  events_seen;

  // latched item
  logic [15:0] ae_in;
  logic [15:0] we_in;
  logic [7:0]  dim_in;
  logic [47:0] ts_in;
  logic [15:0] w_eff;      // weight clamped to one
  logic [15:0] w_comp;     // one minus weight

  // shared multiplier and accumulator
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] prod;
  logic [31:0] acc;
  logic [31:0] ema_sum;
  logic [15:0] ema_val;

  // square root datapath
  logic [31:0] sq_rem;
  logic [31:0] sq_root;
  logic [31:0] sq_bit;
  logic [31:0] sq_trial;
  logic [15:0] level_val;

  // result side
  logic        fired;
  logic [5:0]  events_next;
  logic        out_free;

  function automatic logic [15:0] clamp_unit(input logic [16:0] v);
    return (v > {1'b0, Q_ONE}) ? Q_ONE : v[15:0];
  endfunction

  function automatic logic [2:0] band_of(input logic [15:0] lv);
    priority if (lv >= BAND_FULL)    return LB_FULL;
    else if (lv >= BAND_HIGH)        return LB_HIGH;
    else if (lv >= BAND_MEDIUM)      return LB_MEDIUM;
    else if (lv >= BAND_LOW)         return LB_LOW;
    else if (lv >= BAND_NASCENT)     return LB_NASCENT;
    else                             return LB_DORMANT;
  endfunction

  // the weight is to change only while idle; the block does not enforce this, it is written straight through
  assign cfg_ready = 1'b1;

  // one item at a time; a result still waiting downstream does not block
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // operand selection for the shared multiplier:
  //   0: old ae average * (1 - w)   1: ae sample * w
  //   2: old we average * (1 - w)   3: we sample * w
  //   5: new ae average * new we average (the square root radicand)
  always_comb begin
    unique case (step)
      3'd0: begin
        mul_a = ae_avg;
        mul_b = w_comp;
      end
      3'd1: begin
        mul_a = ae_in;
        mul_b = w_eff;
      end
      3'd2: begin
        mul_a = we_avg;
        mul_b = w_comp;
      end
      3'd3: begin
        mul_a = we_in;
        mul_b = w_eff;
      end
      default: begin
        mul_a = ae_avg;
        mul_b = we_avg;
      end
    endcase
  end

  // second half of a moving average update, rounded half up
  assign ema_sum = acc + prod;
  assign ema_val = clamp_unit(ema_sum[31:15]);

  // one result bit per cycle
  assign sq_bit   = 32'd1 << {sq_idx, 1'b0};
  assign sq_trial = sq_root + sq_bit;

  assign level_val = clamp_unit(sq_root[16:0]);

  assign fired = (ae_in >= FIRE_SAMPLE_MIN) && (ae_avg > FIRE_AVG_ABOVE);
  assign events_next = (fired && events_seen < EVENT_LIMIT) ? events_seen + 6'd1
                                                            : events_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= 3'd0;
      sq_idx      <= 4'd0;
      weight      <= WEIGHT_RESET;
      ae_avg      <= 16'd0;
      we_avg      <= 16'd0;
      events_seen <= 6'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        weight <= cfg_data;
      end

      // result beat taken, unless the next one is loaded at the same edge
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            ae_in  <= clamp_unit({1'b0, in_data.ae_sample});
            we_in  <= clamp_unit({1'b0, in_data.we_sample});
            dim_in <= in_data.dimension;
            ts_in  <= in_data.time_stamp;
            w_eff  <= clamp_unit({1'b0, weight});
            w_comp <= Q_ONE - clamp_unit({1'b0, weight});
            step   <= 3'd0;
            state  <= S_EMA;
          end
        end

        S_EMA: begin
          prod <= 32'(mul_a) * 32'(mul_b);
          step <= step + 3'd1;
          unique case (step)
            3'd1, 3'd3: acc <= prod + Q_HALF;
            3'd2:       ae_avg <= ema_val;
            3'd4:       we_avg <= ema_val;
            3'd6: begin
              // radicand ready: start the digit-by-digit root
              sq_rem  <= prod;
              sq_root <= 32'd0;
              sq_idx  <= 4'd15;
              state   <= S_SQRT;
            end
            default: ;
          endcase
        end

        S_SQRT: begin
          if (sq_rem >= sq_trial) begin
            sq_rem  <= sq_rem - sq_trial;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          if (sq_idx == 4'd0) begin
            state <= S_DONE;
          end else begin
            sq_idx <= sq_idx - 4'd1;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.avg_ae          <= ae_avg;
            out_data.avg_we          <= we_avg;
            out_data.level           <= level_val;
            out_data.level_band      <= band_of(level_val);
            out_data.event_fired     <= fired;
            out_data.event_dimension <= fired ? dim_in : 8'd0;
            out_data.event_time      <= fired ? ts_in : 48'd0;
            out_data.event_total     <= events_next;
            events_seen              <= events_next;
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // the event count never passes its limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    events_seen <= EVENT_LIMIT)
    else $error("event count beyond limit");

  // the count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (events_seen == $past(events_seen)) ||
                    (events_seen == $past(events_seen) + 6'd1))
    else $error("event count jumped");

  // a quiet result carries no tag or time
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_fired |->
      (out_data.event_dimension == 8'd0) && (out_data.event_time == 48'd0))
    else $error("tag or time on a result without event");

  // the level and both averages stay within one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.level <= Q_ONE) && (out_data.avg_ae <= Q_ONE) &&
                  (out_data.avg_we <= Q_ONE))
    else $error("result above one");

  // a result is only loaded at the end of the sequence
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat without finished item");
`endif

endmodule
